@@ sv/uartb_pkg.sv @@
`timescale 1ns / 1ps

package uartb_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 512;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Operation selector
	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_SERVICE = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	// Per-cycle queue control
	typedef struct packed {
		logic clr;
		logic push;
		logic pop;
	} queue_ctl_t;

endpackage

@@ sv/uartb_queue.sv @@
`timescale 1ns / 1ps

module uartb_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  uartb_pkg::queue_ctl_t  ctl,
	input  logic [7:0]             push_data,
	output logic [uartb_pkg::CNT_W-1:0] cnt,
	output logic [7:0]             pop_data
);
	import uartb_pkg::*;

	logic [7:0]       mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       rd_data_s1;
	logic [7:0]       push_data_s1;
	logic             fwd_s1;

	// Wrap a pointer at the queue depth
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			fwd_s1 <= 1'b0;
		end else if (ctl.clr) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			fwd_s1 <= 1'b0;
		end else begin
			if (ctl.push) begin
				head_q <= next_ptr(head_q);
			end
			if (ctl.pop) begin
				tail_q <= next_ptr(tail_q);
			end
			cnt_q  <= cnt_q + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
			// pop of an empty queue in the same cycle as a push returns the pushed byte
			fwd_s1 <= ctl.push && ctl.pop && (cnt_q == '0);
		end
	end

	// Store pushed byte, read popped byte
	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clr) begin
			mem[head_q] <= push_data;
		end
		if (ctl.pop) begin
			rd_data_s1 <= mem[tail_q];
		end
		push_data_s1 <= push_data;
	end

	assign cnt      = cnt_q;
	assign pop_data = fwd_s1 ? push_data_s1 : rd_data_s1;

endmodule

@@ sv/uart_buffered_tx_rx_bridge.sv @@
`timescale 1ns / 1ps
// The result of a command accepted at one edge is shown with done high for the following
// cycle, and the receiver cannot stall it.
// Throughput: one command per cycle; busy stays low, since each queue does one memory
// write and one registered memory read per command.
// Reset: arst_n clears pointers, counts, busy flag and interrupt enable; the stores are
// not cleared; a clear command resets the same state except the result strobes.
module uart_buffered_tx_rx_bridge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [7:0]                  wr_byte,
	input  logic                        batch_last,
	input  logic                        tx_empty,
	input  logic                        rx_full,
	input  logic                        noise_err,
	input  logic                        frame_err,
	input  logic [7:0]                  rx_byte,
	output logic                        done,
	output logic                        write_accepted,
	output logic                        read_valid,
	output logic [7:0]                  read_byte,
	output logic                        tx_valid,
	output logic [7:0]                  tx_byte,
	output logic                        tx_irq_enable,
	output logic [uartb_pkg::CNT_W-1:0] write_free,
	output logic                        rx_overflow
);
	import uartb_pkg::*;

	func_t            op;
	logic             acc;
	queue_ctl_t       tx_ctl;
	queue_ctl_t       rx_ctl;
	logic [CNT_W-1:0] tx_cnt;
	logic [CNT_W-1:0] rx_cnt;
	logic [7:0]       tx_pop_data;
	logic [7:0]       rx_pop_data;
	logic             tx_full;
	logic             rx_full_q;
	logic             rx_good;
	logic             overflow;
	logic             start_tx;

	logic tx_busy_q;
	logic tx_irq_q;
	logic done_s1;
	logic write_acc_s1;
	logic read_valid_s1;
	logic tx_valid_s1;
	logic overflow_s1;

	assign busy = 1'b0;
	assign acc  = start && !busy;
	assign op   = func_t'(func);

	assign tx_full   = (tx_cnt == CNT_W'(QUEUE_DEPTH));
	assign rx_full_q = (rx_cnt == CNT_W'(QUEUE_DEPTH));
	assign rx_good   = rx_full && !noise_err && !frame_err;

	// Decode the command into queue transfers
	always_comb begin
		tx_ctl   = '0;
		rx_ctl   = '0;
		overflow = 1'b0;
		start_tx = 1'b0;
		if (acc) begin
			unique case (op)
				FUNC_WRITE: begin
					tx_ctl.push = !tx_full;
					start_tx    = batch_last && !tx_busy_q && (tx_cnt != '0 || !tx_full);
					tx_ctl.pop  = start_tx;
				end
				FUNC_READ: begin
					rx_ctl.pop = (rx_cnt != '0);
				end
				FUNC_SERVICE: begin
					tx_ctl.pop  = (tx_cnt != '0) && tx_empty;
					rx_ctl.push = rx_good && !rx_full_q;
					overflow    = rx_good && rx_full_q;
				end
				FUNC_CLEAR: begin
					tx_ctl.clr = 1'b1;
					rx_ctl.clr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	uartb_queue u_tx_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tx_ctl),
		.push_data(wr_byte),
		.cnt      (tx_cnt),
		.pop_data (tx_pop_data)
	);

	uartb_queue u_rx_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rx_ctl),
		.push_data(rx_byte),
		.cnt      (rx_cnt),
		.pop_data (rx_pop_data)
	);

	// Update transmitter flags and register the result strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_busy_q     <= 1'b0;
			tx_irq_q      <= 1'b0;
			done_s1       <= 1'b0;
			write_acc_s1  <= 1'b0;
			read_valid_s1 <= 1'b0;
			tx_valid_s1   <= 1'b0;
			overflow_s1   <= 1'b0;
		end else begin
			done_s1       <= acc;
			write_acc_s1  <= tx_ctl.push;
			read_valid_s1 <= rx_ctl.pop;
			tx_valid_s1   <= tx_ctl.pop;
			overflow_s1   <= overflow;
			if (tx_ctl.clr) begin
				tx_busy_q <= 1'b0;
				tx_irq_q  <= 1'b0;
			end else if (start_tx) begin
				tx_busy_q <= 1'b1;
				tx_irq_q  <= 1'b1;
			end else if (acc && op == FUNC_SERVICE) begin
				if (tx_cnt == '0) begin
					tx_busy_q <= 1'b0;
					tx_irq_q  <= 1'b0;
				end else if (tx_empty) begin
					tx_busy_q <= 1'b1;
				end
			end
		end
	end

	// Drive the result, zero the bytes that do not apply
	assign done           = done_s1;
	assign write_accepted = write_acc_s1;
	assign read_valid     = read_valid_s1;
	assign read_byte      = read_valid_s1 ? rx_pop_data : 8'd0;
	assign tx_valid       = tx_valid_s1;
	assign tx_byte        = tx_valid_s1 ? tx_pop_data : 8'd0;
	assign tx_irq_enable  = tx_irq_q;
	assign write_free     = CNT_W'(QUEUE_DEPTH) - tx_cnt;
	assign rx_overflow    = overflow_s1;

endmodule

@@ test/uart_buffered_tx_rx_bridge_tb.sv @@
`timescale 1ns / 1ps

module uart_buffered_tx_rx_bridge_tb;
	import uartb_pkg::*;

	// One host or UART command as it is driven into the bridge
	typedef struct {
		func_t      func;
		logic [7:0] wr_byte;
		logic       batch_last;
		logic       tx_empty;
		logic       rx_full;
		logic       noise_err;
		logic       frame_err;
		logic [7:0] rx_byte;
	} bridge_cmd_t;

	// One result as shown on the result ports
	typedef struct packed {
		logic             write_accepted;
		logic             read_valid;
		logic [7:0]       read_byte;
		logic             tx_valid;
		logic [7:0]       tx_byte;
		logic             tx_irq_enable;
		logic [CNT_W-1:0] write_free;
		logic             rx_overflow;
	} bridge_result_t;

	class bridge_scoreboard;
		logic [7:0]     tx_mem[QUEUE_DEPTH];
		logic [7:0]     rx_mem[QUEUE_DEPTH];
		int unsigned    tx_wr, tx_rd, tx_cnt;
		int unsigned    rx_wr, rx_rd, rx_cnt;
		bit             tx_active, irq_on;
		bridge_result_t pending[$];
		int unsigned    n_errors, n_checked;
		int unsigned    n_sent, n_reads, n_refused, n_overflow, n_clears;

		function void empty_queues();
			tx_wr = 0; tx_rd = 0; tx_cnt = 0;
			rx_wr = 0; rx_rd = 0; rx_cnt = 0;
			tx_active = 0;
			irq_on = 0;
		endfunction

		function logic [7:0] pop_tx();
			logic [7:0] b;
			b = tx_mem[tx_rd];
			tx_rd = (tx_rd + 1) % QUEUE_DEPTH;
			tx_cnt--;
			n_sent++;
			return b;
		endfunction

		function void flag(string what);
			n_errors++;
			if (n_errors <= 10)
				$display("[%0t] ERROR: %s", $realtime, what);
		endfunction

		function string show(bridge_result_t r);
			return $sformatf("wa=%0b rv=%0b rb=%02h tv=%0b tb=%02h irq=%0b free=%0d ovf=%0b",
				r.write_accepted, r.read_valid, r.read_byte, r.tx_valid, r.tx_byte,
				r.tx_irq_enable, r.write_free, r.rx_overflow);
		endfunction

		// Advance the predicted bridge state by one accepted command
		function void note_command(bridge_cmd_t c);
			bridge_result_t r;
			r = '0;
			case (c.func)
				FUNC_WRITE: begin
					if (tx_cnt < QUEUE_DEPTH) begin
						tx_mem[tx_wr] = c.wr_byte;
						tx_wr = (tx_wr + 1) % QUEUE_DEPTH;
						tx_cnt++;
						r.write_accepted = 1'b1;
					end else begin
						n_refused++;
					end
					// start transmission on the last byte of a batch if idle
					if (c.batch_last && !tx_active && tx_cnt > 0) begin
						r.tx_byte = pop_tx();
						r.tx_valid = 1'b1;
						tx_active = 1;
						irq_on = 1;
					end
				end
				FUNC_READ: begin
					if (rx_cnt > 0) begin
						r.read_byte = rx_mem[rx_rd];
						r.read_valid = 1'b1;
						rx_rd = (rx_rd + 1) % QUEUE_DEPTH;
						rx_cnt--;
						n_reads++;
					end
				end
				FUNC_SERVICE: begin
					if (tx_cnt > 0) begin
						if (c.tx_empty) begin
							r.tx_byte = pop_tx();
							r.tx_valid = 1'b1;
							tx_active = 1;
						end
					end else begin
						irq_on = 0;
						tx_active = 0;
					end
					// take in the received byte unless it is damaged
					if (c.rx_full && !c.noise_err && !c.frame_err) begin
						if (rx_cnt < QUEUE_DEPTH) begin
							rx_mem[rx_wr] = c.rx_byte;
							rx_wr = (rx_wr + 1) % QUEUE_DEPTH;
							rx_cnt++;
						end else begin
							r.rx_overflow = 1'b1;
							n_overflow++;
						end
					end
				end
				default: begin
					empty_queues();
					n_clears++;
				end
			endcase
			r.tx_irq_enable = irq_on;
			r.write_free = CNT_W'(QUEUE_DEPTH - tx_cnt);
			pending.push_back(r);
		endfunction

		// Compare one transfer from the bridge with the oldest prediction
		function void check_result(bridge_result_t got);
			bridge_result_t want;
			string bad;
			if (pending.size() == 0) begin
				flag($sformatf("result with no command pending: %s", show(got)));
				return;
			end
			want = pending.pop_front();
			n_checked++;
			bad = "";
			if (got.write_accepted !== want.write_accepted) bad = {bad, " write_accepted"};
			if (got.read_valid !== want.read_valid) bad = {bad, " read_valid"};
			if (got.read_byte !== want.read_byte) bad = {bad, " read_byte"};
			if (got.tx_valid !== want.tx_valid) bad = {bad, " tx_valid"};
			if (got.tx_byte !== want.tx_byte) bad = {bad, " tx_byte"};
			if (got.tx_irq_enable !== want.tx_irq_enable) bad = {bad, " tx_irq_enable"};
			if (got.write_free !== want.write_free) bad = {bad, " write_free"};
			if (got.rx_overflow !== want.rx_overflow) bad = {bad, " rx_overflow"};
			if (bad != "")
				flag($sformatf("mismatch on%s: expected %s, got %s", bad, show(want), show(got)));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	func_t            func;
	logic [7:0]       wr_byte;
	logic             batch_last;
	logic             tx_empty;
	logic             rx_full;
	logic             noise_err;
	logic             frame_err;
	logic [7:0]       rx_byte;
	logic             done;
	logic             write_accepted;
	logic             read_valid;
	logic [7:0]       read_byte;
	logic             tx_valid;
	logic [7:0]       tx_byte;
	logic             tx_irq_enable;
	logic [CNT_W-1:0] write_free;
	logic             rx_overflow;

	bridge_scoreboard sb;
	int unsigned      idle_pct;
	int unsigned      n_issued;

	uart_buffered_tx_rx_bridge i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.wr_byte        (wr_byte),
		.batch_last     (batch_last),
		.tx_empty       (tx_empty),
		.rx_full        (rx_full),
		.noise_err      (noise_err),
		.frame_err      (frame_err),
		.rx_byte        (rx_byte),
		.done           (done),
		.write_accepted (write_accepted),
		.read_valid     (read_valid),
		.read_byte      (read_byte),
		.tx_valid       (tx_valid),
		.tx_byte        (tx_byte),
		.tx_irq_enable  (tx_irq_enable),
		.write_free     (write_free),
		.rx_overflow    (rx_overflow)
	);

	// 100 MHz clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Sample results mid-cycle, away from the driving edge
	always @(negedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result({write_accepted, read_valid, read_byte, tx_valid, tx_byte,
				tx_irq_enable, write_free, rx_overflow});
		else if (arst_n && done !== 1'b0)
			sb.flag("done strobe is unknown");
	end

	function automatic bridge_cmd_t random_cmd();
		bridge_cmd_t c;
		c.func       = func_t'($urandom_range(3));
		c.wr_byte    = 8'($urandom);
		c.batch_last = 1'($urandom);
		c.tx_empty   = 1'($urandom);
		c.rx_full    = 1'($urandom);
		c.noise_err  = 1'($urandom);
		c.frame_err  = 1'($urandom);
		c.rx_byte    = 8'($urandom);
		return c;
	endfunction

	// Drive one command and hold it until the bridge takes the transfer
	task automatic issue(input bridge_cmd_t c);
		bit stalled;
		// idle each cycle with the chosen probability
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		func       <= c.func;
		wr_byte    <= c.wr_byte;
		batch_last <= c.batch_last;
		tx_empty   <= c.tx_empty;
		rx_full    <= c.rx_full;
		noise_err  <= c.noise_err;
		frame_err  <= c.frame_err;
		rx_byte    <= c.rx_byte;
		do begin
			@(negedge clk);
			stalled = (busy !== 1'b0);
			@(posedge clk);
		end while (stalled);
		sb.note_command(c);
		n_issued++;
	endtask

	task automatic do_write(input logic [7:0] b, input logic last);
		bridge_cmd_t c;
		c = random_cmd();
		c.func = FUNC_WRITE;
		c.wr_byte = b;
		c.batch_last = last;
		issue(c);
	endtask

	task automatic do_service(input logic te, input logic rf, input logic ne,
			input logic fe, input logic [7:0] b);
		bridge_cmd_t c;
		c = random_cmd();
		c.func = FUNC_SERVICE;
		c.tx_empty = te;
		c.rx_full = rf;
		c.noise_err = ne;
		c.frame_err = fe;
		c.rx_byte = b;
		issue(c);
	endtask

	task automatic do_op(input func_t f);
		bridge_cmd_t c;
		c = random_cmd();
		c.func = f;
		issue(c);
	endtask

	// Mixed traffic: write batches, service bursts, host reads, rare clears and noise
	task automatic random_traffic(input int unsigned count);
		int unsigned stop_at, kind, len;
		stop_at = n_issued + count;
		while (n_issued < stop_at) begin
			kind = $urandom_range(99);
			len = $urandom_range(8, 1);
			if (kind < 35) begin
				for (int i = 1; i <= len; i++)
					do_write(8'($urandom), i == len);
			end else if (kind < 65) begin
				repeat (len)
					do_service($urandom_range(3) != 0, $urandom_range(3) != 0,
						$urandom_range(7) == 0, $urandom_range(7) == 0, 8'($urandom));
			end else if (kind < 85) begin
				repeat (len) do_op(FUNC_READ);
			end else if (kind < 88) begin
				do_op(FUNC_CLEAR);
			end else begin
				issue(random_cmd());
			end
		end
	endtask

	initial begin
		int unsigned waited;
		sb = new();
		sb.empty_queues();
		idle_pct = 0;
		n_issued = 0;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		func       <= FUNC_READ;
		wr_byte    <= '0;
		batch_last <= 1'b0;
		tx_empty   <= 1'b0;
		rx_full    <= 1'b0;
		noise_err  <= 1'b0;
		frame_err  <= 1'b0;
		rx_byte    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queues, batch start, busy hold, error discards, stop, clear
		do_op(FUNC_READ);
		do_service(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
		do_write(8'h00, 1'b0);
		do_write(8'hFF, 1'b1);
		do_write(8'hA5, 1'b1);
		do_service(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
		do_service(1'b1, 1'b1, 1'b0, 1'b0, 8'hFF);
		do_service(1'b1, 1'b1, 1'b1, 1'b0, 8'h11);
		do_service(1'b0, 1'b1, 1'b0, 1'b1, 8'h22);
		do_service(1'b0, 1'b1, 1'b1, 1'b1, 8'h33);
		do_service(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
		do_op(FUNC_READ);
		do_op(FUNC_READ);
		do_op(FUNC_READ);
		do_write(8'h5A, 1'b0);
		do_service(1'b1, 1'b1, 1'b0, 1'b0, 8'h80);
		do_op(FUNC_CLEAR);
		do_op(FUNC_READ);
		do_write(8'h7F, 1'b1);
		do_op(FUNC_CLEAR);

		// Random traffic under three idling patterns
		idle_pct = 32;
		random_traffic(177);
		idle_pct = 56;
		random_traffic(177);
		idle_pct = 0;
		random_traffic(177);
		start <= 1'b0;

		// Let the last results come out
		waited = 0;
		while (sb.pending.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.flag($sformatf("%0d results never arrived", sb.pending.size()));

		$display("Covered %0d commands, %0d results checked, %0d bytes sent, %0d host reads",
			n_issued, sb.n_checked, sb.n_sent, sb.n_reads);
		$display("Writes refused when full: %0d, receive overflows: %0d, clears: %0d, errors: %0d",
			sb.n_refused, sb.n_overflow, sb.n_clears, sb.n_errors);
		if (sb.n_errors == 0)
			$display("uart_buffered_tx_rx_bridge_tb OK");
		else
			$display("uart_buffered_tx_rx_bridge_tb NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("Timeout waiting for the bridge");
		$display("uart_buffered_tx_rx_bridge_tb NOT OK");
		$finish;
	end

endmodule
